// ===== design/piecewise_cubic_curve_evaluator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise cubic curve evaluator
// Concurrent checks on the design's own clock; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_CUBIC_CURVE_EVALUATOR_ASSERT_SVH
`define PIECEWISE_CUBIC_CURVE_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS

// check while out of reset
`define PCCE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcce assertion failed");

// check that also spans the reset itself
`define PCCE_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pcce reset assertion failed");

`else

`define PCCE_ASSERT(lbl, clk, rst_n, prop)
`define PCCE_ASSERT_RST(lbl, clk, prop)

`endif

`endif

// ===== design/pcce_pkg.sv =====
// ----------------------------------------------------------------------------
// pcce_pkg
// Shared widths, opcodes, key record and saturating fixed-point helpers.
// ----------------------------------------------------------------------------
package pcce_pkg;

    localparam int DATA_W        = 32;
    localparam int DEF_MAX_KEYS  = 16;
    localparam int DEF_FRAC_BITS = 16;
    localparam int OPC_W         = 2;
    localparam int KIDX_W        = 4;
    localparam int KEYS_W        = 5;
    localparam int S_TDATA_W     = 200;  // 196 bits of fields, padded to bytes
    localparam int M_TDATA_W     = 32;

    localparam logic [OPC_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPC_W-1:0] OP_EVAL  = 2'd1;
    localparam logic [OPC_W-1:0] OP_MAX   = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] tm;
        logic signed [DATA_W-1:0] cub;
        logic signed [DATA_W-1:0] quad;
        logic signed [DATA_W-1:0] lin;
        logic signed [DATA_W-1:0] cst;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_fx_res;

    // clamp a wide signed value to 32 bits, flag if clamped
    function automatic t_fx_res fx_clamp(input logic signed [63:0] v);
        t_fx_res r;
        if (v > 64'sd2147483647) begin
            r.value = 32'sh7FFF_FFFF;
            r.sat   = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.value = 32'sh8000_0000;
            r.sat   = 1'b1;
        end else begin
            r.value = v[DATA_W-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

    function automatic t_fx_res fx_add(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
        logic signed [DATA_W:0] s;
        s = 33'(a) + 33'(b);
        return fx_clamp(64'(s));
    endfunction

endpackage

// ===== design/piecewise_cubic_curve_evaluator.sv =====
// ----------------------------------------------------------------------------
// piecewise_cubic_curve_evaluator
// Keyed cubic curve: key writes, evaluation at x and curve maximum.
// ----------------------------------------------------------------------------
// One word in, one word out. tuser selects the operation: 0 stores a key
// (time, cubic, quadratic, linear, constant) in slot key_index, 1 evaluates
// the curve at position, 2 returns the curve maximum. Unknown operations and
// writes answer with value 0, flag 0. Evaluation scans the keys in use from
// slot 0 and stops at the first key whose time is above x; the key before it
// is used (slot 0 if the very first key is already above x, the last key in
// use if none is). The maximum evaluates every key in use at its own time and
// the last key at x = 1. All arithmetic is signed fixed point with FRAC_BITS
// fraction bits; every product and sum saturates to 32 bits and sets the
// saturation flag on m_axis_tuser. One item is in flight at a time; the next
// word is taken as soon as the previous result sits in the output register.
// An evaluate runs the scan, the polynomial and the hand-off in turn; a maximum
// runs the polynomial for each key in use, then the tail. All products go
// through the single shared multiplier (five products per polynomial), and
// keys come through the one read port of the key RAM.
// Key slots must be written before they are read. keys_in_use (cfg port)
// resets to 1; 0 acts as 1, values above MAX_KEYS act as MAX_KEYS.
// ----------------------------------------------------------------------------
`include "piecewise_cubic_curve_evaluator_assert.svh"

module piecewise_cubic_curve_evaluator #(
    parameter int MAX_KEYS  = pcce_pkg::DEF_MAX_KEYS,
    parameter int FRAC_BITS = pcce_pkg::DEF_FRAC_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] key_index, [35:4] key_time, [67:36] cubic_coef,
    // [99:68] quadratic_coef, [131:100] linear_coef,
    // [163:132] constant_coef, [195:164] position, [199:196] zero
    input  logic [pcce_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  logic [pcce_pkg::OPC_W-1:0]       s_axis_tuser,
    // result words
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [31:0] curve_value
    output logic [pcce_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] saturated
    output logic                             m_axis_tuser,
    // keys_in_use register
    input  logic                             i_cfg_wr_en,
    input  logic [pcce_pkg::KEYS_W-1:0]      i_cfg_wr_data
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int DW = pcce_pkg::DATA_W;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,  // key search for an evaluate
        S_LOAD  = 8'b0000_0100,  // read request for one key of a maximum
        S_LATCH = 8'b0000_1000,  // key data back from RAM
        S_MUL   = 8'b0001_0000,  // operands into the multiplier
        S_ACC   = 8'b0010_0000,  // product back, accumulate
        S_FIN   = 8'b0100_0000,  // add constant term, track maximum
        S_TAIL  = 8'b1000_0000   // last key at x = 1, final compare
    } t_state;

    // separate hand-off state kept out of the one-hot set of the datapath
    logic r_done;

    // polynomial steps
    localparam logic [2:0] ST_X2 = 3'd0;
    localparam logic [2:0] ST_QT = 3'd1;
    localparam logic [2:0] ST_X3 = 3'd2;
    localparam logic [2:0] ST_CT = 3'd3;
    localparam logic [2:0] ST_LT = 3'd4;

    // tail steps of the maximum
    localparam logic [1:0] TL_CQ  = 2'd0;
    localparam logic [1:0] TL_L   = 2'd1;
    localparam logic [1:0] TL_K   = 2'd2;
    localparam logic [1:0] TL_CMP = 2'd3;

    // input fields
    logic [pcce_pkg::KIDX_W-1:0] w_key_index;
    pcce_pkg::t_key              w_wr_key;
    logic signed [DW-1:0]        w_position;

    assign w_key_index     = s_axis_tdata[3:0];
    assign w_wr_key.tm     = s_axis_tdata[35:4];
    assign w_wr_key.cub    = s_axis_tdata[67:36];
    assign w_wr_key.quad   = s_axis_tdata[99:68];
    assign w_wr_key.lin    = s_axis_tdata[131:100];
    assign w_wr_key.cst    = s_axis_tdata[163:132];
    assign w_position      = s_axis_tdata[195:164];

    // registers
    t_state                      r_state, n_state;
    logic                        n_done;
    logic [pcce_pkg::OPC_W-1:0]  r_op, n_op;
    logic signed [DW-1:0]        r_x, n_x;
    pcce_pkg::t_key              r_key, n_key;
    logic signed [DW-1:0]        r_x2, n_x2;
    logic signed [DW-1:0]        r_x3, n_x3;
    logic signed [DW-1:0]        r_acc, n_acc;
    logic signed [DW-1:0]        r_best, n_best;
    logic                        r_sat, n_sat;
    logic [2:0]                  r_step, n_step;
    logic [1:0]                  r_tail, n_tail;
    logic [AW-1:0]               r_addr, n_addr;
    logic [AW-1:0]               r_cnt, n_cnt;
    logic                        r_first, n_first;
    logic [pcce_pkg::KEYS_W-1:0] r_keys;
    logic                        r_ovalid;
    logic signed [DW-1:0]        r_ovalue;
    logic                        r_osat;

    logic                        w_in_fire;
    logic                        w_out_load;
    logic                        w_ram_we;
    logic [AW-1:0]               w_raddr;
    pcce_pkg::t_key              w_rd_key;
    logic [AW-1:0]               w_last;
    logic signed [DW-1:0]        w_mul_a, w_mul_b;
    pcce_pkg::t_fx_res           w_mul;
    pcce_pkg::t_fx_res           w_add_m;
    pcce_pkg::t_fx_res           w_add_k;
    pcce_pkg::t_fx_res           w_add_t;
    logic                        w_gt;

    // ready whenever no item is in flight; the output register decouples
    assign s_axis_tready = (r_state == S_IDLE) && !r_done;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = r_done && (!r_ovalid || m_axis_tready);

    // index of the last key in use
    always_comb begin
        if (r_keys == '0) begin
            w_last = '0;
        end else if (int'(r_keys) > MAX_KEYS) begin
            w_last = AW'(MAX_KEYS - 1);
        end else begin
            w_last = AW'(r_keys - 5'd1);
        end
    end

    // key store: writes only at accept, read data used only while busy
    assign w_ram_we = w_in_fire && (s_axis_tuser == pcce_pkg::OP_WRITE) &&
                      (int'(w_key_index) < MAX_KEYS);
    assign w_raddr  = (r_state == S_LOAD) ? r_cnt : r_addr;

    pcce_ram #(
        .WIDTH (pcce_pkg::KEY_W),
        .DEPTH (MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (AW'(w_key_index)),
        .i_wdata (w_wr_key),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_key)
    );

    // shared multiplier operands
    always_comb begin
        case (r_step)
            ST_X2:   begin w_mul_a = r_x;       w_mul_b = r_x;  end
            ST_QT:   begin w_mul_a = r_key.quad; w_mul_b = r_x2; end
            ST_X3:   begin w_mul_a = r_x;       w_mul_b = r_x2; end
            ST_CT:   begin w_mul_a = r_key.cub;  w_mul_b = r_x3; end
            ST_LT:   begin w_mul_a = r_key.lin;  w_mul_b = r_x;  end
            default: begin w_mul_a = r_x;       w_mul_b = r_x;  end
        endcase
    end

    pcce_fxmul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fxmul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_res (w_mul)
    );

    assign w_add_m = pcce_pkg::fx_add(w_mul.value, r_acc);
    assign w_add_k = pcce_pkg::fx_add(r_key.cst, r_acc);
    assign w_gt    = w_rd_key.tm > r_x;

    always_comb begin
        case (r_tail)
            TL_CQ:   w_add_t = pcce_pkg::fx_add(r_key.cub, r_key.quad);
            TL_L:    w_add_t = pcce_pkg::fx_add(r_acc, r_key.lin);
            default: w_add_t = pcce_pkg::fx_add(r_acc, r_key.cst);
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        n_op    = r_op;
        n_x     = r_x;
        n_key   = r_key;
        n_x2    = r_x2;
        n_x3    = r_x3;
        n_acc   = r_acc;
        n_best  = r_best;
        n_sat   = r_sat;
        n_step  = r_step;
        n_tail  = r_tail;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_first = r_first;

        if (w_out_load) begin
            n_done = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_op    = s_axis_tuser;
                    n_sat   = 1'b0;
                    n_acc   = '0;
                    n_cnt   = '0;
                    n_addr  = '0;
                    n_first = 1'b1;
                    n_x     = w_position;
                    case (s_axis_tuser)
                        pcce_pkg::OP_EVAL: n_state = S_SCAN;
                        pcce_pkg::OP_MAX:  n_state = S_LOAD;
                        default:           n_done  = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                // read pipelined one slot ahead of the compare
                n_first = 1'b0;
                if (r_addr != w_last) begin
                    n_addr = r_addr + 1'b1;
                end
                if (!r_first) begin
                    if (r_cnt == '0 || !w_gt) begin
                        n_key = w_rd_key;
                    end
                    if (w_gt || r_cnt == w_last) begin
                        n_step  = ST_X2;
                        n_state = S_MUL;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_LOAD: begin
                n_state = S_LATCH;
            end
            S_LATCH: begin
                n_key   = w_rd_key;
                n_x     = w_rd_key.tm;
                n_step  = ST_X2;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                case (r_step)
                    ST_X2: begin
                        n_x2  = w_mul.value;
                        n_sat = r_sat | w_mul.sat;
                    end
                    ST_QT: begin
                        n_acc = w_mul.value;
                        n_sat = r_sat | w_mul.sat;
                    end
                    ST_X3: begin
                        n_x3  = w_mul.value;
                        n_sat = r_sat | w_mul.sat;
                    end
                    default: begin
                        n_acc = w_add_m.value;
                        n_sat = r_sat | w_mul.sat | w_add_m.sat;
                    end
                endcase
                if (r_step == ST_LT) begin
                    n_state = S_FIN;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_MUL;
                end
            end
            S_FIN: begin
                n_acc = w_add_k.value;
                n_sat = r_sat | w_add_k.sat;
                if (r_op == pcce_pkg::OP_MAX) begin
                    if (r_cnt == '0 || w_add_k.value > r_best) begin
                        n_best = w_add_k.value;
                    end
                    if (r_cnt == w_last) begin
                        n_tail  = TL_CQ;
                        n_state = S_TAIL;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_LOAD;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TAIL: begin
                // r_key still holds the last key in use
                if (r_tail == TL_CMP) begin
                    n_acc   = (r_acc > r_best) ? r_acc : r_best;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_acc  = w_add_t.value;
                    n_sat  = r_sat | w_add_t.sat;
                    n_tail = r_tail + 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_done   <= 1'b0;
            r_keys   <= 5'd1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_wr_en) begin
                r_keys <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_x     <= n_x;
        r_key   <= n_key;
        r_x2    <= n_x2;
        r_x3    <= n_x3;
        r_acc   <= n_acc;
        r_best  <= n_best;
        r_sat   <= n_sat;
        r_step  <= n_step;
        r_tail  <= n_tail;
        r_addr  <= n_addr;
        r_cnt   <= n_cnt;
        r_first <= n_first;
        if (w_out_load) begin
            r_ovalue <= r_acc;
            r_osat   <= r_sat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ovalue;
    assign m_axis_tuser  = r_osat;

    // checks
    `PCCE_ASSERT(a_wr_only_idle, i_clk, i_rst_n, (w_ram_we |-> (r_state == S_IDLE)))
    `PCCE_ASSERT(a_out_from_done, i_clk, i_rst_n, ($rose(r_ovalid) |-> $past(r_done)))
    `PCCE_ASSERT(a_wr_result_zero, i_clk, i_rst_n, ((r_done && r_op != pcce_pkg::OP_EVAL && r_op != pcce_pkg::OP_MAX) |-> (r_acc == '0 && !r_sat)))
    `PCCE_ASSERT(a_scan_bound, i_clk, i_rst_n, ((r_state == S_SCAN && !r_first) |-> (r_cnt <= w_last)))
    `PCCE_ASSERT_RST(a_reset_idle, i_clk, (!i_rst_n |=> (r_state == S_IDLE && !r_ovalid && !r_done)))

endmodule

// ===== design/pcce_ram.sv =====
// ----------------------------------------------------------------------------
// pcce_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcce_ram #(
    parameter int WIDTH = pcce_pkg::KEY_W,
    parameter int DEPTH = pcce_pkg::DEF_MAX_KEYS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pcce_fxmul.sv =====
// ----------------------------------------------------------------------------
// pcce_fxmul
// Fixed-point multiply: registered 32x32 product, then floor shift and clamp.
// ----------------------------------------------------------------------------
module pcce_fxmul #(
    parameter int FRAC_BITS = pcce_pkg::DEF_FRAC_BITS
) (
    input  logic                               i_clk,
    input  logic signed [pcce_pkg::DATA_W-1:0] i_a,
    input  logic signed [pcce_pkg::DATA_W-1:0] i_b,
    output pcce_pkg::t_fx_res                  o_res
);

    logic signed [2*pcce_pkg::DATA_W-1:0] w_prod;
    logic signed [2*pcce_pkg::DATA_W-1:0] r_prod;
    logic signed [2*pcce_pkg::DATA_W-1:0] w_shift;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // arithmetic shift rounds toward minus infinity
    assign w_shift = r_prod >>> FRAC_BITS;
    assign o_res   = pcce_pkg::fx_clamp(w_shift);

endmodule

// ===== bench/piecewise_cubic_curve_evaluator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_cubic_curve_evaluator_tb
// Self-checking bench: key writes, evaluations and maximum scans are streamed
// in with random gaps and back-pressure, every result word is compared with a
// cycle-free fixed-point model of the curve kept inside the bench.
// ----------------------------------------------------------------------------
module piecewise_cubic_curve_evaluator_tb;

    // opcode 3 has no name in the package: the block answers 0 / 0
    localparam logic [pcce_pkg::OPC_W-1:0] OP_NONE = 2'd3;

    localparam int FRAC            = pcce_pkg::DEF_FRAC_BITS;
    localparam int SLOTS           = pcce_pkg::DEF_MAX_KEYS;
    localparam int IDLE_PCT        = 11;
    localparam int HOLD_CYCLES     = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES    = 250;   // longer than the worst item
    localparam int PHASES          = 10;
    localparam int WORDS_PER_PHASE = 160;

    localparam logic signed [pcce_pkg::DATA_W-1:0] FX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [pcce_pkg::DATA_W-1:0] FX_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [pcce_pkg::OPC_W-1:0]     op;
        logic [pcce_pkg::S_TDATA_W-1:0] data;
    } t_curve_word;

    typedef struct packed {
        logic signed [pcce_pkg::DATA_W-1:0] curve_value;
        logic                               saturated;
    } t_curve_answer;

    // ------------------------------------------------------------------------
    // DUT signals, inputs known from time zero
    // ------------------------------------------------------------------------
    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [pcce_pkg::S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic [pcce_pkg::OPC_W-1:0]       s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [pcce_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             i_cfg_wr_en   = 1'b0;
    logic [pcce_pkg::KEYS_W-1:0]      i_cfg_wr_data = '0;

    piecewise_cubic_curve_evaluator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_curve_word   queued_words[$];       // words waiting for the driver
    t_curve_answer curve_answers_due[$];  // predicted results, oldest first
    t_curve_word   next_word;
    t_curve_answer due;

    // model copy of the key table and the key count register
    pcce_pkg::t_key               key_table[SLOTS];
    logic [pcce_pkg::KEYS_W-1:0]  keys_live = 5'd1;
    bit                           clip_seen;

    // times as queued, used to aim positions at key boundaries
    logic signed [pcce_pkg::DATA_W-1:0] plan_times[SLOTS];

    int words_offered = 0;
    int words_taken   = 0;
    int idle_pct      = IDLE_PCT;
    bit stall_req     = 1'b0;
    bit stall_used    = 1'b0;
    int hold_left     = 0;

    int err_cnt      = 0;
    int write_cnt    = 0;
    int eval_cnt     = 0;
    int max_cnt      = 0;
    int none_cnt     = 0;
    int cfg_cnt      = 0;
    int results_seen = 0;
    int sat_seen     = 0;

    task automatic report_err(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Fixed-point model: exact 64-bit product, floor shift, clamp to 32 bits.
    // Any clamp raises clip_seen, which becomes the saturated flag.
    // ------------------------------------------------------------------------
    function automatic logic signed [pcce_pkg::DATA_W-1:0] clip32(
        input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            clip_seen = 1'b1;
            return FX_MAX;
        end
        if (v < -64'sd2147483648) begin
            clip_seen = 1'b1;
            return FX_MIN;
        end
        return v[pcce_pkg::DATA_W-1:0];
    endfunction

    function automatic logic signed [pcce_pkg::DATA_W-1:0] fx_product(
        input logic signed [pcce_pkg::DATA_W-1:0] a,
        input logic signed [pcce_pkg::DATA_W-1:0] b);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        wide_a = a;
        wide_b = b;
        return clip32((wide_a * wide_b) >>> FRAC);  // >>> on signed = floor
    endfunction

    function automatic logic signed [pcce_pkg::DATA_W-1:0] fx_total(
        input logic signed [pcce_pkg::DATA_W-1:0] a,
        input logic signed [pcce_pkg::DATA_W-1:0] b);
        logic signed [63:0] wide_a;
        logic signed [63:0] wide_b;
        wide_a = a;
        wide_b = b;
        return clip32(wide_a + wide_b);
    endfunction

    // c*x^3 + q*x^2 + l*x + k in the block's order of operations
    function automatic logic signed [pcce_pkg::DATA_W-1:0] cubic_at(
        input int k, input logic signed [pcce_pkg::DATA_W-1:0] x);
        logic signed [pcce_pkg::DATA_W-1:0] x2;
        logic signed [pcce_pkg::DATA_W-1:0] qt;
        logic signed [pcce_pkg::DATA_W-1:0] x3;
        logic signed [pcce_pkg::DATA_W-1:0] r;
        x2 = fx_product(x, x);
        qt = fx_product(key_table[k].quad, x2);
        x3 = fx_product(x, x2);
        r  = fx_total(fx_product(key_table[k].cub, x3), qt);
        r  = fx_total(fx_product(key_table[k].lin, x), r);
        return fx_total(key_table[k].cst, r);
    endfunction

    // Result of one accepted word; also updates the model's key table.
    function automatic t_curve_answer predict_curve_word(input t_curve_word w);
        t_curve_answer                      ans;
        logic [pcce_pkg::KIDX_W-1:0]        slot;
        logic signed [pcce_pkg::DATA_W-1:0] x;
        logic signed [pcce_pkg::DATA_W-1:0] best;
        logic signed [pcce_pkg::DATA_W-1:0] v;
        int                                 n;
        int                                 i;
        clip_seen       = 1'b0;
        ans.curve_value = '0;
        slot            = w.data[3:0];
        x               = w.data[195:164];
        // key count register: 0 acts as 1, above the table size as the size
        n = (keys_live == 0) ? 1 : ((keys_live > SLOTS) ? SLOTS : int'(keys_live));
        case (w.op)
            pcce_pkg::OP_WRITE: begin
                key_table[slot].tm   = w.data[35:4];
                key_table[slot].cub  = w.data[67:36];
                key_table[slot].quad = w.data[99:68];
                key_table[slot].lin  = w.data[131:100];
                key_table[slot].cst  = w.data[163:132];
                write_cnt++;
            end
            pcce_pkg::OP_EVAL: begin
                // scan stops at the first key above x; before key 0 uses key 0
                i = 0;
                while (i < n && key_table[i].tm <= x)
                    i++;
                ans.curve_value = cubic_at((i > 0) ? i - 1 : 0, x);
                eval_cnt++;
            end
            pcce_pkg::OP_MAX: begin
                best = cubic_at(0, key_table[0].tm);
                for (i = 1; i < n; i++) begin
                    v = cubic_at(i, key_table[i].tm);
                    if (v > best)
                        best = v;
                end
                // last key in use at x = 1
                v = fx_total(fx_total(fx_total(key_table[n-1].cub, key_table[n-1].quad),
                                      key_table[n-1].lin), key_table[n-1].cst);
                if (v > best)
                    best = v;
                ans.curve_value = best;
                max_cnt++;
            end
            OP_NONE: begin
                none_cnt++;
            end
            default: ;
        endcase
        ans.saturated = clip_seen;
        return ans;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_curve_word make_word(
        input logic [pcce_pkg::OPC_W-1:0]         op,
        input logic [pcce_pkg::KIDX_W-1:0]        slot,
        input pcce_pkg::t_key                     k,
        input logic signed [pcce_pkg::DATA_W-1:0] pos);
        t_curve_word w;
        w.op   = op;
        w.data = {4'b0, pos, k.cst, k.lin, k.quad, k.cub, k.tm, slot};
        return w;
    endfunction

    // mostly small coefficients (about +-2.0), some extremes and full range
    function automatic logic signed [pcce_pkg::DATA_W-1:0] rand_coef();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? FX_MAX : FX_MIN;
            default: return $signed($urandom_range(262143)) - 32'sd131072;
        endcase
    endfunction

    // positions aimed at key times, just off them, before key 0, or anywhere
    function automatic logic signed [pcce_pkg::DATA_W-1:0] rand_position();
        int i;
        i = $urandom_range(SLOTS - 1);
        case ($urandom_range(7))
            0:       return plan_times[i];
            1:       return plan_times[i] + $signed($urandom_range(2047)) - 32'sd1024;
            2:       return plan_times[0] - 32'sd1 - $signed($urandom_range(65535));
            3:       return $urandom;
            4:       return $urandom_range(1) ? FX_MAX : FX_MIN;
            default: return plan_times[i] + $signed($urandom_range(65535));
        endcase
    endfunction

    // a well-formed curve: all slots, key times ascending
    task automatic queue_curve_rewrite();
        pcce_pkg::t_key                     k;
        logic signed [pcce_pkg::DATA_W-1:0] t;
        int                                 s;
        t = -$signed($urandom_range(1 << 20));
        for (s = 0; s < SLOTS; s++) begin
            k.tm   = t;
            k.cub  = rand_coef();
            k.quad = rand_coef();
            k.lin  = rand_coef();
            k.cst  = rand_coef();
            plan_times[s] = t;
            queued_words.push_back(make_word(pcce_pkg::OP_WRITE,
                                             s[pcce_pkg::KIDX_W-1:0], k, $urandom));
            t = t + $signed($urandom_range(65536, 1));
        end
    endtask

    // unused fields always carry random bits
    task automatic queue_random_word();
        pcce_pkg::t_key              k;
        logic [pcce_pkg::KIDX_W-1:0] slot;
        int                          pick;
        k.tm   = $urandom;
        k.cub  = $urandom;
        k.quad = $urandom;
        k.lin  = $urandom;
        k.cst  = $urandom;
        slot   = 4'($urandom_range(SLOTS - 1));
        pick   = $urandom_range(99);
        if (pick < 25) begin
            // usually keep the slot's time (curve stays ordered), else break it
            if ($urandom_range(4) != 0)
                k.tm = plan_times[slot];
            else
                plan_times[slot] = k.tm;
            k.cub  = rand_coef();
            k.quad = rand_coef();
            k.lin  = rand_coef();
            k.cst  = rand_coef();
            queued_words.push_back(make_word(pcce_pkg::OP_WRITE, slot, k, $urandom));
        end else if (pick < 83) begin
            queued_words.push_back(make_word(pcce_pkg::OP_EVAL, slot, k, rand_position()));
        end else if (pick < 95) begin
            queued_words.push_back(make_word(pcce_pkg::OP_MAX, slot, k, $urandom));
        end else begin
            queued_words.push_back(make_word(OP_NONE, slot, k, $urandom));
        end
    endtask

    // sender pause: nothing queued, nothing in flight, nothing due
    task automatic wait_drained();
        while (queued_words.size() != 0 || words_offered != words_taken ||
               curve_answers_due.size() != 0)
            @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_key_count(input logic [pcce_pkg::KEYS_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        keys_live = v;
        cfg_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: a new word goes out once the previous one was taken
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && words_taken == words_offered) begin
            if (queued_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_word      = queued_words.pop_front();
                s_axis_tdata  <= next_word.data;
                s_axis_tuser  <= next_word.op;
                s_axis_tvalid <= 1'b1;
                words_offered <= words_offered + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_req && !stall_used) begin
            stall_used    <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Predictor and checker, both on the rising edge; prediction first
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                curve_answers_due.push_back(predict_curve_word({s_axis_tuser, s_axis_tdata}));
                words_taken <= words_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (curve_answers_due.size() == 0) begin
                    report_err("unexpected result word", m_axis_tdata, 32'h0);
                end else begin
                    due = curve_answers_due.pop_front();
                    if (m_axis_tdata !== due.curve_value)
                        report_err("curve_value", m_axis_tdata, due.curve_value);
                    if (m_axis_tuser !== due.saturated)
                        report_err("saturated", {31'b0, m_axis_tuser}, {31'b0, due.saturated});
                    results_seen++;
                    if (due.saturated)
                        sat_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        pcce_pkg::t_key              k;
        logic [pcce_pkg::KEYS_W-1:0] live;
        int                          s;
        int                          p;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ordered keys, slot 14 all max coefficients, slot 15 all
        // min coefficients at the largest time; every slot written first.
        for (s = 0; s < SLOTS; s++) begin
            k.tm   = (s == SLOTS - 1) ? FX_MAX : 32'((s * 3 - 20) * 65536);
            k.cub  = rand_coef();
            k.quad = rand_coef();
            k.lin  = rand_coef();
            k.cst  = rand_coef();
            if (s == 0) begin
                k.cub  = '0;
                k.quad = '0;
                k.lin  = 32'sd65536;
                k.cst  = -32'sd1;
            end else if (s == SLOTS - 2) begin
                k.cub  = FX_MAX;
                k.quad = FX_MAX;
                k.lin  = FX_MAX;
                k.cst  = FX_MAX;
            end else if (s == SLOTS - 1) begin
                k.cub  = FX_MIN;
                k.quad = FX_MIN;
                k.lin  = FX_MIN;
                k.cst  = FX_MIN;
            end
            plan_times[s] = k.tm;
            queued_words.push_back(make_word(pcce_pkg::OP_WRITE, s[pcce_pkg::KIDX_W-1:0], k,
                                             (s % 2 == 1) ? 32'hFFFF_FFFF : 32'h0));
        end
        // reset key count of one: only key 0 takes part
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd0, k, FX_MIN));
        queued_words.push_back(make_word(pcce_pkg::OP_MAX, 4'd0, k, 32'sd0));
        wait_drained();

        write_key_count(5'd16);
        // before key 0
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd0, k, FX_MIN));
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd5, k, plan_times[5]));
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd5, k,
                                         plan_times[5] + 32'sd32768));
        // last key, clamps
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd15, k, FX_MAX));
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd6, k, 32'sd0));
        queued_words.push_back(make_word(pcce_pkg::OP_EVAL, 4'd14, k, plan_times[SLOTS-2]));
        queued_words.push_back(make_word(pcce_pkg::OP_MAX, 4'd15, k, 32'sd0));
        queued_words.push_back(make_word(OP_NONE, 4'd15, k, FX_MAX));
        wait_drained();

        // Random phases, each under its own key count; the first five hit
        // the extremes and the out-of-range counts.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       live = 5'd16;
                1:       live = 5'd1;
                2:       live = 5'd0;
                3:       live = 5'd31;
                4:       live = 5'd17;
                default: live = 5'($urandom_range(16, 2));
            endcase
            idle_pct = (p == 5) ? 0 : IDLE_PCT;  // one stretch with no gaps
            write_key_count(live);
            queue_curve_rewrite();
            for (s = 0; s < WORDS_PER_PHASE; s++)
                queue_random_word();
            // receiver holds off while the sender keeps offering
            if (p == 3)
                stall_req = 1'b1;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d key writes, %0d evaluations, %0d maximum scans, %0d unknown ops",
                 write_cnt, eval_cnt, max_cnt, none_cnt);
        $display("under %0d key-count settings; %0d results checked, %0d with clamping",
                 cfg_cnt, results_seen, sat_seen);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #25_000_000;
        $display("run timed out");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/pcce_pkg.sv
design/pcce_ram.sv
design/pcce_fxmul.sv
design/piecewise_cubic_curve_evaluator.sv
bench/piecewise_cubic_curve_evaluator_tb.sv
